### design/uartrx_pkg.sv
// Shared constants for the 8N1 serial receiver with receive FIFO.
package uartrx_pkg;

    // Receive FIFO geometry.
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Bit period register and tick counter widths.
    localparam int PERIOD_W = 9;
    localparam int TICK_W   = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd104;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 9'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 9'd256;

    // Bit counter width and number of data bits per frame.
    localparam int BIT_W = 4;
    localparam logic [BIT_W-1:0] DATA_BITS = 4'd8;

    // Receiver phase codes.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

endpackage

### design/uart_rx_8n1_with_fifo.sv
// Top level: 8N1 serial receiver with a 16-entry receive FIFO.
//
// Each input word is one timer tick carrying the sampled rx line level and a
// read request; every tick yields exactly one output word with the popped
// byte (or zero), a pop flag and the FIFO fill level after the tick. The
// block takes one tick per clock cycle while out_stall is low: a tick passes
// through an input register and then the receiver, FIFO and read logic into
// the output register, which offers its result word. A falling edge while
// idle starts a frame; the start bit is sampled (bit_period - 1) / 4 ticks
// later (at least one), later bits bit_period ticks apart. A high start
// sample aborts, a high stop bit pushes the byte (dropped when the FIFO is
// full), and a low stop bit discards it. Within one tick the push is done
// before the pop, so a byte received on that tick can be read at once.
// bit_period is written through cfg_wr_en / cfg_wr_data by the user only
// while the block is idle; the block itself does not enforce this. Zero
// acts as one and values above 256 act as 256.
module uart_rx_8n1_with_fifo
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [uartrx_pkg::PERIOD_W-1:0]       cfg_wr_data,
    // Tick input channel.
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  rx_level,
    input  logic                                  read_request,
    // Result output channel.
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [7:0]                            read_data,
    output logic                                  read_valid,
    output logic [uartrx_pkg::CNT_W-1:0]          fifo_level
);

    // Configuration register.
    logic [uartrx_pkg::PERIOD_W-1:0] bit_period_reg;

    // Input register.
    logic s1_valid_reg;
    logic s1_level_reg;
    logic s1_read_reg;

    // Receiver state.
    logic                             line_prev_reg;
    logic [1:0]                       phase_reg;
    logic [uartrx_pkg::TICK_W-1:0]    tick_reg;
    logic [uartrx_pkg::BIT_W-1:0]     bit_index_reg;
    logic [7:0]                       shift_reg;

    // FIFO state.
    logic [7:0]                       fifo_mem [uartrx_pkg::FIFO_DEPTH];
    logic [uartrx_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [uartrx_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [uartrx_pkg::CNT_W-1:0]     count_reg;

    // Output register.
    logic                             out_valid_reg;
    logic [7:0]                       read_data_reg;
    logic                             read_valid_reg;
    logic [uartrx_pkg::CNT_W-1:0]     fifo_level_reg;

    // Next-state values.
    logic [1:0]                       phase_next;
    logic [uartrx_pkg::TICK_W-1:0]    tick_next;
    logic [uartrx_pkg::BIT_W-1:0]     bit_index_next;
    logic [7:0]                       shift_next;
    logic [uartrx_pkg::CNT_W-1:0]     count_next;
    logic [uartrx_pkg::PTR_W-1:0]     wr_ptr_next;
    logic [uartrx_pkg::PTR_W-1:0]     rd_ptr_next;

    // Helper signals.
    logic                             advance;
    logic                             in_accept;
    logic [uartrx_pkg::PERIOD_W-1:0]  period_eff;
    logic [uartrx_pkg::PERIOD_W-1:0]  period_m1;
    logic [uartrx_pkg::TICK_W-1:0]    start_delay;
    logic [uartrx_pkg::TICK_W-1:0]    start_load;
    logic                             push;
    logic                             pop;
    logic                             bypass;
    logic [uartrx_pkg::CNT_W-1:0]     count_mid;
    logic [uartrx_pkg::BIT_W-1:0]     bit_index_inc;

    // Handshake: a tick moves on when the output register is free or drains.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Effective bit period and the derived counter loads.
    always_comb
    begin
        if (bit_period_reg == '0)
            period_eff = uartrx_pkg::PERIOD_MIN;
        else if (bit_period_reg > uartrx_pkg::PERIOD_MAX)
            period_eff = uartrx_pkg::PERIOD_MAX;
        else
            period_eff = bit_period_reg;
        period_m1   = period_eff - uartrx_pkg::PERIOD_MIN;
        start_delay = {2'b00, period_m1[7:2]};
        start_load  = (start_delay == '0) ? '0 : start_delay - 8'd1;
    end

    // Receiver sequencing for the tick held in the input register.
    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        push           = 1'b0;
        bit_index_inc  = bit_index_reg + 4'd1;
        if (phase_reg == uartrx_pkg::PH_IDLE)
        begin
            if (line_prev_reg && !s1_level_reg)
            begin
                tick_next      = start_load;
                phase_next     = uartrx_pkg::PH_START;
                bit_index_next = '0;
                shift_next     = '0;
            end
        end
        else if (tick_reg != '0)
        begin
            tick_next = tick_reg - 8'd1;
        end
        else
        begin
            tick_next = period_m1[uartrx_pkg::TICK_W-1:0];
            unique case (phase_reg)
                uartrx_pkg::PH_START:
                begin
                    if (s1_level_reg)
                    begin
                        phase_next = uartrx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next     = uartrx_pkg::PH_DATA;
                        bit_index_next = '0;
                        shift_next     = '0;
                    end
                end
                uartrx_pkg::PH_DATA:
                begin
                    shift_next = shift_reg
                               | (8'(s1_level_reg) << bit_index_reg[2:0]);
                    bit_index_next = bit_index_inc;
                    if (bit_index_inc >= uartrx_pkg::DATA_BITS)
                        phase_next = uartrx_pkg::PH_STOP;
                end
                uartrx_pkg::PH_STOP:
                begin
                    push = s1_level_reg
                        && (count_reg != uartrx_pkg::CNT_W'(uartrx_pkg::FIFO_DEPTH));
                    phase_next     = uartrx_pkg::PH_IDLE;
                    bit_index_next = '0;
                    shift_next     = '0;
                end
                uartrx_pkg::PH_IDLE:
                begin
                    phase_next = uartrx_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // FIFO bookkeeping: the push of this tick comes before its pop.
    always_comb
    begin
        count_mid  = count_reg + uartrx_pkg::CNT_W'(push);
        pop        = s1_read_reg && (count_mid != '0);
        bypass     = (count_reg == '0);
        count_next = count_mid - uartrx_pkg::CNT_W'(pop);
        if (push)
            wr_ptr_next = (wr_ptr_reg == uartrx_pkg::PTR_W'(uartrx_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        else
            wr_ptr_next = wr_ptr_reg;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == uartrx_pkg::PTR_W'(uartrx_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        else
            rd_ptr_next = rd_ptr_reg;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_period_reg <= uartrx_pkg::PERIOD_RESET;
        else if (cfg_wr_en)
            bit_period_reg <= cfg_wr_data;
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_level_reg <= rx_level;
            s1_read_reg  <= read_request;
        end
    end

    // Receiver and FIFO control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_prev_reg <= 1'b1;
            phase_reg     <= uartrx_pkg::PH_IDLE;
            tick_reg      <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else if (advance)
        begin
            line_prev_reg <= s1_level_reg;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    // FIFO storage write.
    always_ff @(posedge clk)
    begin
        if (advance && push)
            fifo_mem[wr_ptr_reg] <= shift_reg;
    end

    // Output word payload; an empty FIFO forwards the byte pushed this tick.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (!pop)
                read_data_reg <= '0;
            else if (bypass)
                read_data_reg <= shift_reg;
            else
                read_data_reg <= fifo_mem[rd_ptr_reg];
            read_valid_reg <= pop;
            fifo_level_reg <= count_next;
        end
    end

    // Output word valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign read_valid = read_valid_reg;
    assign fifo_level = fifo_level_reg;

    // The fill count never exceeds the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= uartrx_pkg::CNT_W'(uartrx_pkg::FIFO_DEPTH))
        else $error("FIFO count above depth");

    // An empty FIFO has its pointers together.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("FIFO pointers apart while empty");

    // While idle the bit counter and shift register are clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == uartrx_pkg::PH_IDLE |-> bit_index_reg == '0 && shift_reg == '0)
        else $error("receiver idle with stale frame state");

    // A read of a non-empty FIFO yields a popped byte in the next output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_read_reg && count_reg != '0 |=> out_valid_reg && read_valid_reg)
        else $error("read of non-empty FIFO gave no byte");

    // The input side stalls only while a tick is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

endmodule

### bench/tb.sv
// Self-checking testbench for the 8N1 serial receiver with its receive FIFO.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0]                  data;
    logic                        valid;
    logic [uartrx_pkg::CNT_W-1:0] level;
} read_word_t;

// Tracks the receiver and FIFO tick by tick and holds the read words still due.
class rx_scoreboard;
    logic [uartrx_pkg::PERIOD_W-1:0] period_reg;
    logic                            line_prev;
    logic [1:0]                      phase;
    logic [uartrx_pkg::TICK_W-1:0]   tick_cnt;
    logic [uartrx_pkg::BIT_W-1:0]    bit_idx;
    logic [7:0]                      shift_byte;
    logic [7:0]                      store [uartrx_pkg::FIFO_DEPTH];
    logic [uartrx_pkg::PTR_W-1:0]    wr_ptr;
    logic [uartrx_pkg::PTR_W-1:0]    rd_ptr;
    logic [uartrx_pkg::CNT_W-1:0]    count;
    read_word_t                      expected_q [$];
    int                              errors;

    function new();
        period_reg = uartrx_pkg::PERIOD_RESET;
        line_prev  = 1'b1;
        phase      = uartrx_pkg::PH_IDLE;
        tick_cnt   = '0;
        bit_idx    = '0;
        shift_byte = '0;
        wr_ptr     = '0;
        rd_ptr     = '0;
        count      = '0;
        errors     = 0;
    endfunction

    function void set_period(logic [uartrx_pkg::PERIOD_W-1:0] v);
        period_reg = v;
    endfunction

    // Zero behaves as one, and anything past 256 is clipped to 256.
    function int bit_ticks();
        int p;
        p = int'(period_reg);
        if (p < int'(uartrx_pkg::PERIOD_MIN)) p = int'(uartrx_pkg::PERIOD_MIN);
        if (p > int'(uartrx_pkg::PERIOD_MAX)) p = int'(uartrx_pkg::PERIOD_MAX);
        return p;
    endfunction

    function bit rx_idle();
        return phase == uartrx_pkg::PH_IDLE;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the receiver by one accepted tick and queue the read word it produces.
    function void note_tick(logic rx, logic rd);
        int         p;
        int         d;
        read_word_t w;
        p = bit_ticks();
        w = '0;

        // Reception first: edge detect while idle, otherwise count down to the next sample.
        if (phase == uartrx_pkg::PH_IDLE)
        begin
            if (line_prev && !rx)
            begin
                d          = (p - 1) >> 2;
                tick_cnt   = uartrx_pkg::TICK_W'((d == 0) ? 0 : d - 1);
                phase      = uartrx_pkg::PH_START;
                bit_idx    = '0;
                shift_byte = '0;
            end
        end
        else if (tick_cnt != '0)
        begin
            tick_cnt = tick_cnt - 1'b1;
        end
        else
        begin
            tick_cnt = uartrx_pkg::TICK_W'(p - 1);
            case (phase)
                uartrx_pkg::PH_START:
                begin
                    if (rx)
                    begin
                        phase = uartrx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase      = uartrx_pkg::PH_DATA;
                        bit_idx    = '0;
                        shift_byte = '0;
                    end
                end
                uartrx_pkg::PH_DATA:
                begin
                    if (rx) shift_byte[bit_idx[2:0]] = 1'b1;
                    bit_idx = bit_idx + 1'b1;
                    if (bit_idx >= uartrx_pkg::DATA_BITS) phase = uartrx_pkg::PH_STOP;
                end
                default:
                begin
                    // A good stop bit pushes the byte unless the FIFO is full.
                    if (rx && count < uartrx_pkg::FIFO_DEPTH)
                    begin
                        store[wr_ptr] = shift_byte;
                        wr_ptr = (wr_ptr == uartrx_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
                        count  = count + 1'b1;
                    end
                    phase      = uartrx_pkg::PH_IDLE;
                    bit_idx    = '0;
                    shift_byte = '0;
                end
            endcase
        end
        line_prev = rx;

        // The read is served after reception, so a byte can be popped on its stop tick.
        if (rd && count != '0)
        begin
            w.data  = store[rd_ptr];
            w.valid = 1'b1;
            rd_ptr  = (rd_ptr == uartrx_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
            count   = count - 1'b1;
        end
        w.level = count;
        expected_q.push_back(w);
    endfunction

    // Compare one accepted result word with the oldest expected word.
    function void check_result(logic [7:0] data, logic valid,
                               logic [uartrx_pkg::CNT_W-1:0] level);
        read_word_t w;
        if (expected_q.size() == 0)
        begin
            $error("result word with none expected: read_data %0d read_valid %0b fifo_level %0d",
                   data, valid, level);
            errors++;
            return;
        end
        w = expected_q.pop_front();
        if (data !== w.data)
        begin
            $error("read_data: expected %0d, got %0d", w.data, data);
            errors++;
        end
        if (valid !== w.valid)
        begin
            $error("read_valid: expected %0b, got %0b", w.valid, valid);
            errors++;
        end
        if (level !== w.level)
        begin
            $error("fifo_level: expected %0d, got %0d", w.level, level);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int LIMIT = 2_000_000;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_wr_en    = 1'b0;
    logic [uartrx_pkg::PERIOD_W-1:0] cfg_wr_data  = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic                            rx_level     = 1'b1;
    logic                            read_request = 1'b0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic [7:0]                      read_data;
    logic                            read_valid;
    logic [uartrx_pkg::CNT_W-1:0]    fifo_level;

    rx_scoreboard sb;
    bit           calm_in     = 1'b0;
    bit           calm_out    = 1'b0;
    int           read_pct    = 0;
    int           stall_left  = 0;
    int           cycle_count = 0;

    uart_rx_8n1_with_fifo u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_level     (rx_level),
        .read_request (read_request),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .read_valid   (read_valid),
        .fifo_level   (fifo_level)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stalls: mostly short bursts, now and then a long one.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (!calm_out && $urandom_range(0, 99) < 25)
        begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20)
                                                     : $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Every result word accepted at this edge is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(read_data, read_valid, fifo_level);
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("uart_rx_8n1_with_fifo: mismatch");
        $finish;
    end

    function bit pick_read();
        return $urandom_range(0, 99) < read_pct;
    endfunction

    // Offer one tick word, with an occasional idle gap ahead of it, and wait for acceptance.
    task send_tick(input logic rx, input logic rd);
        int gap;
        if (!calm_in && $urandom_range(0, 99) < 30)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        rx_level     <= rx;
        read_request <= rd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_tick(rx, rd);
    endtask

    // Hold the line high until the receiver is back in idle.
    task settle_line();
        while (!sb.rx_idle()) send_tick(1'b1, pick_read());
    endtask

    // One frame aligned to the current bit period. A high start level ends it at the
    // start sample; noisy puts random levels on ticks that are not sample points.
    task send_frame(input logic [7:0] value, input logic start_lvl, input logic stop_lvl,
                    input bit noisy);
        int   p;
        int   s0;
        int   last;
        int   k;
        int   t;
        logic lvl;
        settle_line();
        p    = sb.bit_ticks();
        s0   = ((p - 1) >> 2 == 0) ? 1 : (p - 1) >> 2;
        last = start_lvl ? s0 : s0 + 9 * p;
        repeat ($urandom_range(1, 3)) send_tick(1'b1, pick_read());
        send_tick(1'b0, pick_read());
        for (t = 1; t <= last; t++)
        begin
            k = (t <= s0) ? 0 : (t - s0 + p - 1) / p;
            case (k)
                0:       lvl = (t == s0) ? start_lvl : 1'b0;
                9:       lvl = stop_lvl;
                default: lvl = value[k-1];
            endcase
            if (noisy && t != s0 + k * p) lvl = 1'($urandom_range(0, 1));
            send_tick(lvl, pick_read());
        end
    endtask

    // Bring the block to rest, wait for every result word, then write the bit period.
    task write_period(input logic [uartrx_pkg::PERIOD_W-1:0] v);
        settle_line();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_period(v);
    endtask

    initial
    begin
        int ph;
        int r;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset period: a read from the empty FIFO, then a false start.
        read_pct = 100;
        send_tick(1'b1, 1'b1);
        send_frame(8'h00, 1'b1, 1'b1, 1'b0);

        // Period of four: extreme bytes, bad stop, held-low line, false start.
        write_period(9'd4);
        read_pct = 0;
        send_frame(8'h00, 1'b0, 1'b1, 1'b0);
        send_frame(8'hFF, 1'b0, 1'b1, 1'b0);
        send_frame(8'h5A, 1'b0, 1'b0, 1'b0);
        repeat (8) send_tick(1'b0, 1'b0);
        send_frame(8'h3C, 1'b1, 1'b1, 1'b0);

        // Zero period acts as one: overfill so the last byte is dropped, then drain past empty.
        write_period(9'd0);
        repeat (15) send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
        repeat (20) send_tick(1'b1, 1'b1);

        // Period of one with every read on: each byte is popped on its own stop tick.
        write_period(9'd1);
        read_pct = 100;
        repeat (2) send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);

        // Longest period, and the largest register value which is clipped to it.
        read_pct = 2;
        write_period(9'd256);
        send_frame(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
        write_period(9'd511);
        send_frame(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);

        // Random phases: mostly clean frames with random bytes, some broken ones and noise.
        for (ph = 0; ph < 4; ph++)
        begin
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       read_pct = 0;
                1:       read_pct = 3;
                2:       read_pct = 10;
                default: read_pct = 40;
            endcase
            write_period(9'($urandom_range(0, 6)));
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b1, $urandom_range(0, 2) == 0);
            end
            else if (r < 85)
            begin
                send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) != 0)
                    repeat ($urandom_range(1, 3 * sb.bit_ticks())) send_tick(1'b0, pick_read());
            end
            else if (r < 92)
            begin
                send_frame(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    send_tick(1'($urandom_range(0, 1)), pick_read());
            end
        end

        // Let the last result words come out, then give the verdict.
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("uart_rx_8n1_with_fifo: match");
        else
            $display("uart_rx_8n1_with_fifo: mismatch");
        $finish;
    end
endmodule

### sim.f
design/uartrx_pkg.sv
design/uart_rx_8n1_with_fifo.sv
bench/tb.sv
